// ===== src/dfr_pkg.sv =====
// Shared types and constants for the telemetry frame deframer.
// Used by every module of the block; depends on nothing.
package dfr_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChStar   = 8'h2A;

  // Frame bytes 2..29 hold the id, the values and the time field.
  localparam int unsigned StoreBase  = 2;
  localparam int unsigned StoreBytes = 28;

  typedef enum logic [2:0] {
    KIND_RAW   = 3'd0,
    KIND_ATT   = 3'd1,
    KIND_BIAS  = 3'd2,
    KIND_OTHER = 3'd3,
    KIND_BAD   = 3'd4,
    KIND_LONG  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_RAW  = 2'd0,
    CFG_ATT  = 2'd1,
    CFG_BIAS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] raw_id;
    logic [7:0] att_id;
    logic [7:0] bias_id;
  } cfg_t;

  // One finished frame handed from the parser to the result sequencer.
  typedef struct packed {
    kind_e                       kind;
    logic [StoreBytes-1:0][7:0]  data;
  } job_t;

endpackage

// ===== src/dfr_if.sv =====
// Handshake channels of the deframer: received bytes, results, register writes.
// Depends on nothing.
interface dfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_result_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  frame_kind;
  logic        [2:0]  value_index;
  logic signed [31:0] value;
  logic        [7:0]  message_id;
  logic               last;
  modport source (output valid, output frame_kind, output value_index, output value,
                  output message_id, output last, input ready);
  modport sink   (input valid, input frame_kind, input value_index, input value,
                  input message_id, input last, output ready);
endinterface

interface dfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dfr_front.sv =====
// Byte parser: header hunt, body capture, checksum and frame classification.
// Depends on dfr_pkg; pushes one job per finished or dropped frame.
module dfr_front #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  output logic           byte_ready_o,
  input  logic [7:0]     rx_byte_i,
  input  dfr_pkg::cfg_t  cfg_i,
  input  logic           job_full_i,
  output logic           job_push_o,
  output dfr_pkg::job_t  job_o
);

  localparam int unsigned LenW = $clog2(MAX_FRAME + 1);

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_DOLLAR = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_STAR   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [7:0]        xor_q, xor_d;
  logic              open_q, open_d;
  logic [7:0]        store_q [dfr_pkg::StoreBytes];
  logic              store_we;
  logic              accept;
  logic [dfr_pkg::StoreBytes-1:0][7:0] masked;
  logic [7:0]        id;

  assign byte_ready_o = !job_full_i;
  assign accept       = byte_valid_i && byte_ready_o;

  // Bytes past the frame length read as zero.
  always_comb begin
    for (int k = 0; k < dfr_pkg::StoreBytes; k++) begin
      masked[k] = (LenW'(k + dfr_pkg::StoreBase) < len_q) ? store_q[k] : 8'h00;
    end
  end
  assign id = masked[0];

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    xor_d      = xor_q;
    open_d     = open_q;
    store_we   = 1'b0;
    job_push_o = 1'b0;
    job_o.data = masked;
    job_o.kind = dfr_pkg::KIND_OTHER;
    if (accept) begin
      case (phase_q)
        PH_DOLLAR: begin
          if (rx_byte_i == dfr_pkg::ChAt) begin
            len_d   = LenW'(2);
            xor_d   = dfr_pkg::ChAt;
            open_d  = 1'b1;
            phase_d = PH_BODY;
          end else if (rx_byte_i != dfr_pkg::ChDollar) begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY, PH_STAR: begin
          if (len_q >= LenW'(MAX_FRAME)) begin
            job_push_o = 1'b1;
            job_o.kind = dfr_pkg::KIND_LONG;
            phase_d    = PH_HUNT;
            len_d      = '0;
            xor_d      = '0;
            open_d     = 1'b0;
          end else begin
            store_we = 1'b1;
            len_d    = len_q + LenW'(1);
            if (open_q) begin
              if (rx_byte_i == dfr_pkg::ChStar) begin
                open_d = 1'b0;
              end else if (rx_byte_i != dfr_pkg::ChDollar) begin
                xor_d = xor_q ^ rx_byte_i;
              end
            end
            if (phase_q == PH_STAR && rx_byte_i == dfr_pkg::ChAt) begin
              phase_d = PH_CHECK;
            end else if (rx_byte_i == dfr_pkg::ChStar) begin
              phase_d = PH_STAR;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_CHECK: begin
          job_push_o = 1'b1;
          if (rx_byte_i != xor_q) begin
            job_o.kind = dfr_pkg::KIND_BAD;
          end else if (id == cfg_i.raw_id) begin
            job_o.kind = dfr_pkg::KIND_RAW;
          end else if (id == cfg_i.att_id) begin
            job_o.kind = dfr_pkg::KIND_ATT;
          end else if (id == cfg_i.bias_id) begin
            job_o.kind = dfr_pkg::KIND_BIAS;
          end else begin
            job_o.kind = dfr_pkg::KIND_OTHER;
          end
          phase_d = PH_HUNT;
          len_d   = '0;
          xor_d   = '0;
          open_d  = 1'b0;
        end
        default: begin
          len_d   = '0;
          xor_d   = '0;
          open_d  = 1'b0;
          phase_d = (rx_byte_i == dfr_pkg::ChDollar) ? PH_DOLLAR : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      xor_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      open_q  <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < dfr_pkg::StoreBytes; k++) begin
      if (store_we && len_q == LenW'(k + dfr_pkg::StoreBase)) begin
        store_q[k] <= rx_byte_i;
      end
    end
  end

endmodule

// ===== src/dfr_job_fifo.sv =====
// Two-entry queue of frame jobs between the parser and the result sequencer.
// Depends on dfr_pkg for the job type.
module dfr_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dfr_pkg::job_t  job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output dfr_pkg::job_t  job_o
);

  dfr_pkg::job_t  mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/dfr_back.sv =====
// Result sequencer: expands one frame job into its values or a status result.
// Depends on dfr_pkg and the result interface; output is registered.
module dfr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  dfr_pkg::job_t  job_i,
  output logic           job_pop_o,
  dfr_result_if.source   res_o
);

  dfr_pkg::job_t      work_q;
  logic               busy_q;
  logic [2:0]         idx_q;
  logic               out_valid_q;
  logic [2:0]         out_kind_q, out_idx_q;
  logic [31:0]        out_value_q;
  logic [7:0]         out_id_q;
  logic               out_last_q;

  logic               load;
  logic [2:0]         last_idx;
  logic               cur_last;
  logic [2:0]         idx_c;
  logic [4:0]         k16, k32;
  logic [31:0]        value_c;

  always_comb begin
    case (work_q.kind)
      dfr_pkg::KIND_RAW:  last_idx = 3'd5;
      dfr_pkg::KIND_ATT:  last_idx = 3'd6;
      dfr_pkg::KIND_BIAS: last_idx = 3'd5;
      default:            last_idx = 3'd0;
    endcase
  end

  assign cur_last = (idx_q == last_idx);
  assign idx_c    = (idx_q > 3'd5) ? 3'd5 : idx_q;
  assign k16      = {1'b0, idx_c, 1'b0} + 5'd2;
  assign k32      = {idx_c, 2'b00} + 5'd2;

  always_comb begin
    case (work_q.kind)
      dfr_pkg::KIND_RAW: begin
        value_c = {{16{work_q.data[k16 + 5'd1][7]}}, work_q.data[k16 + 5'd1],
                   work_q.data[k16]};
      end
      dfr_pkg::KIND_ATT, dfr_pkg::KIND_BIAS: begin
        if (idx_q == 3'd6) begin
          value_c = {{16{work_q.data[27][7]}}, work_q.data[27], work_q.data[26]};
        end else begin
          value_c = {work_q.data[k32 + 5'd3], work_q.data[k32 + 5'd2],
                     work_q.data[k32 + 5'd1], work_q.data[k32]};
        end
      end
      default: value_c = '0;
    endcase
  end

  assign load      = busy_q && (!out_valid_q || res_o.ready);
  assign job_pop_o = job_valid_i && (!busy_q || (load && cur_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (job_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        if (cur_last) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      work_q <= job_i;
    end
    if (load) begin
      out_kind_q  <= work_q.kind;
      out_idx_q   <= idx_q;
      out_value_q <= value_c;
      out_id_q    <= work_q.data[0];
      out_last_q  <= cur_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.frame_kind  = out_kind_q;
  assign res_o.value_index = out_idx_q;
  assign res_o.value       = out_value_q;
  assign res_o.message_id  = out_id_q;
  assign res_o.last        = out_last_q;

endmodule

// ===== src/telemetry_frame_deframer.sv =====
// Channel  | Dir | Payload                                           | Accepted when
// rx_i     | in  | rx_byte[7:0]                                      | valid && ready
// res_o    | out | frame_kind, value_index, value, message_id, last | valid && ready
// cfg_i    | in  | index[1:0], data[7:0]                             | valid && ready
//
// One byte per cycle; rx_i.ready drops only while both job queue entries are taken.
// A frame yields 1, 6 or 7 results, one per cycle from the sequencer's output register while res_o.ready is high.
// First result follows the checksum byte through the queue, the sequencer's work register, then its output register.
// rst_ni clears parser, queue and sequencer control; config resets to 0, 1, 2.
// cfg_i is always ready; writes to index 3 are ignored.
// Top level: register file plus parser, job queue and sequencer; depends on dfr_pkg, dfr_if.
module telemetry_frame_deframer #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfr_byte_if.sink    rx_i,
  dfr_result_if.source res_o,
  dfr_cfg_if.sink     cfg_i
);

  dfr_pkg::cfg_t  cfg_q;
  dfr_pkg::job_t  push_job, pop_job;
  logic           push, pop, q_full, q_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_id  <= 8'd0;
      cfg_q.att_id  <= 8'd1;
      cfg_q.bias_id <= 8'd2;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dfr_pkg::CFG_RAW:  cfg_q.raw_id  <= cfg_i.data;
        dfr_pkg::CFG_ATT:  cfg_q.att_id  <= cfg_i.data;
        dfr_pkg::CFG_BIAS: cfg_q.bias_id <= cfg_i.data;
        default: ;
      endcase
    end
  end

  dfr_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(rx_i.valid),
    .byte_ready_o(rx_i.ready),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_i       (cfg_q),
    .job_full_i  (q_full),
    .job_push_o  (push),
    .job_o       (push_job)
  );

  dfr_job_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .job_o  (pop_job)
  );

  dfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (pop_job),
    .job_pop_o  (pop),
    .res_o      (res_o)
  );

endmodule

// ===== src/dfr_checker.sv =====
// Port-level checks on the deframer's result channel.
// Bound to telemetry_frame_deframer; depends on dfr_pkg for the kind codes.
module dfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [2:0]  res_idx,
  input logic [31:0] res_value,
  input logic        res_last
);

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind == dfr_pkg::KIND_OTHER || res_kind == dfr_pkg::KIND_BAD ||
                  res_kind == dfr_pkg::KIND_LONG)
    |-> res_idx == 3'd0 && res_value == 32'd0 && res_last)
    else $error("status result with value or index");

  a_six_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind == dfr_pkg::KIND_RAW || res_kind == dfr_pkg::KIND_BIAS)
    |-> res_idx <= 3'd5 && (res_last == (res_idx == 3'd5)))
    else $error("raw or bias result out of sequence");

  a_att_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind == dfr_pkg::KIND_ATT |-> res_idx <= 3'd6 &&
    (res_last == (res_idx == 3'd6)))
    else $error("attitude result out of sequence");

  a_raw_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_kind == dfr_pkg::KIND_RAW || res_idx == 3'd6)
    |-> res_value[31:16] == {16{res_value[15]}})
    else $error("16-bit value not sign-extended");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_idx))
    else $error("stalled result changed");

endmodule

bind telemetry_frame_deframer dfr_checker u_dfr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .res_valid(res_o.valid),
  .res_ready(res_o.ready),
  .res_kind (res_o.frame_kind),
  .res_idx  (res_o.value_index),
  .res_value(res_o.value),
  .res_last (res_o.last)
);
